### design/ufold_pkg.sv
`default_nettype none

package ufold_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [7:0] AsciiLimit  = 8'h80;
  localparam logic [7:0] LeadTwoEnd  = 8'hE0;
  localparam logic [7:0] LeadThreeEnd = 8'hF0;
  localparam logic [7:0] UpperA      = 8'h41;
  localparam logic [7:0] UpperZ      = 8'h5A;
  localparam logic [7:0] LowerA      = 8'h61;
  localparam logic [7:0] LowerZ      = 8'h7A;
  localparam logic [7:0] Apostrophe  = 8'h27;
  localparam logic [7:0] CaseBit     = 8'h20;

  localparam logic [CpW-1:0] CyrCapFirst = 21'h000410;
  localparam logic [CpW-1:0] CyrCapLast  = 21'h00042F;
  localparam logic [CpW-1:0] CyrIoCap    = 21'h000401;
  localparam logic [CpW-1:0] CyrIoSmall  = 21'h000451;
  localparam logic [CpW-1:0] CyrFoldStep = 21'h000020;

  localparam logic [CpW-1:0] OneByteEnd   = 21'h000080;
  localparam logic [CpW-1:0] TwoByteEnd   = 21'h000800;
  localparam logic [CpW-1:0] ThreeByteEnd = 21'h010000;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           empty;
    logic           word_end;
  } job_t;

endpackage

`default_nettype wire

### design/ufold_in_if.sv
`default_nettype none

interface ufold_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       token_end;

  modport source (output valid, output in_byte, output token_end, input ready);
  modport sink (input valid, input in_byte, input token_end, output ready);
endinterface

`default_nettype wire

### design/ufold_out_if.sv
`default_nettype none

interface ufold_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       word_end;
  logic       run_last;

  modport source (
    output valid, output out_byte, output byte_valid, output word_end, output run_last,
    input ready
  );
  modport sink (
    input valid, input out_byte, input byte_valid, input word_end, input run_last,
    output ready
  );
endinterface

`default_nettype wire

### design/utf8_word_case_folder_top.sv
// Word case folder: cleans a word token given one byte per item on in_i and
// delivers the cleaned UTF-8 bytes on out_o, one byte per item.
// An input item carries in_byte and token_end; an output item carries
// out_byte, byte_valid, word_end and run_last. A token end that yields no
// data byte produces one empty end marker with byte_valid low.
// The front stage decodes, filters and folds each byte in its accept cycle
// and queues at most one code point per input item. The back stage encodes
// that code point and sends its 1 to 4 bytes, one per cycle while out_o is ready.
// The first result of an item passes through the queue and then the back
// stage's byte register before it is offered.
// Throughput: one input item per cycle while the queue has room; the back
// stage emits one result item per cycle while out_o is ready, so a multi-byte
// code point holds it and the queue of QUEUE_DEPTH entries absorbs the difference.
// When the receiver stalls, the offered item holds and the queue fills; in_i
// ready falls only once the queue is full.
// Reset clears the open sequence, empties the queue and drops out_o valid.
`default_nettype none

module utf8_word_case_folder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ufold_in_if.sink    in_i,
  ufold_out_if.source out_o
);
  import ufold_pkg::*;

  logic push;
  logic room;
  logic q_valid;
  logic pop;
  job_t push_job;
  job_t head_job;

  ufold_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push),
    .job_o  (push_job)
  );

  ufold_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .room_o  (room),
    .valid_o (q_valid),
    .data_o  (head_job),
    .pop_i   (pop)
  );

  ufold_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .job_i   (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.run_last |=> out_o.valid)
    else $error("Multi-byte run broken before its last byte.");

  a_marker_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.byte_valid |-> out_o.word_end && out_o.run_last)
    else $error("Empty end marker without word end.");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.byte_valid |-> out_o.out_byte == 8'h00)
    else $error("Empty end marker carries data.");

endmodule

`default_nettype wire

### design/ufold_front.sv
`default_nettype none

module ufold_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ufold_in_if.sink          in_i,
  input  wire logic         room_i,
  output logic              push_o,
  output ufold_pkg::job_t   job_o
);
  import ufold_pkg::*;

  logic [CpW-1:0] cp_q, cp_d;
  logic [1:0]     rem_q, rem_d;
  logic [CpW-1:0] cp_out;
  logic [CpW-1:0] cp_fold;
  logic           have;
  logic           accept;
  logic [7:0]     b;
  logic           last;

  assign in_i.ready = room_i;
  assign accept     = in_i.valid && room_i;
  assign b          = in_i.in_byte;
  assign last       = in_i.token_end;

  always_comb begin
    cp_d   = cp_q;
    rem_d  = rem_q;
    have   = 1'b0;
    cp_out = '0;
    if (rem_q == 2'd0) begin
      if (b < AsciiLimit) begin
        if (b >= UpperA && b <= UpperZ) begin
          have   = 1'b1;
          cp_out = {13'd0, b | CaseBit};
        end else if ((b >= LowerA && b <= LowerZ) || b == Apostrophe) begin
          have   = 1'b1;
          cp_out = {13'd0, b};
        end
      end else if (b < LeadTwoEnd) begin
        cp_d  = {16'd0, b[4:0]};
        rem_d = 2'd1;
      end else if (b < LeadThreeEnd) begin
        cp_d  = {17'd0, b[3:0]};
        rem_d = 2'd2;
      end else begin
        cp_d  = {18'd0, b[2:0]};
        rem_d = 2'd3;
      end
    end else begin
      cp_d  = {cp_q[CpW-7:0], b[5:0]};
      rem_d = rem_q - 2'd1;
      if (rem_d == 2'd0) begin
        have   = 1'b1;
        cp_out = cp_d;
        cp_d   = '0;
      end
    end
    if (last && rem_d != 2'd0) begin
      have   = 1'b1;
      cp_out = cp_d;
      cp_d   = '0;
      rem_d  = 2'd0;
    end
  end

  always_comb begin
    if (cp_out >= CyrCapFirst && cp_out <= CyrCapLast) begin
      cp_fold = cp_out + CyrFoldStep;
    end else if (cp_out == CyrIoCap) begin
      cp_fold = CyrIoSmall;
    end else begin
      cp_fold = cp_out;
    end
  end

  assign push_o            = accept && (have || last);
  assign job_o.code_point  = have ? cp_fold : '0;
  assign job_o.empty       = !have;
  assign job_o.word_end    = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q  <= '0;
      rem_q <= 2'd0;
    end else if (accept) begin
      cp_q  <= cp_d;
      rem_q <= rem_d;
    end
  end

endmodule

`default_nettype wire

### design/ufold_fifo.sv
`default_nettype none

module ufold_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  ufold_pkg::job_t   data_i,
  output logic              room_o,
  output logic              valid_o,
  output ufold_pkg::job_t   data_o,
  input  wire logic         pop_i
);
  import ufold_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign room_o  = count_q != FullCnt;
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && room_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/ufold_back.sv
`default_nettype none

module ufold_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  input  ufold_pkg::job_t   job_i,
  output logic              pop_o,
  ufold_out_if.source       out_o
);
  import ufold_pkg::*;

  logic [7:0] bytes_q [4];
  logic [7:0] enc [4];
  logic [1:0] last_idx_q, last_idx_d;
  logic [1:0] idx_q;
  logic       busy_q;
  logic       word_end_q;
  logic       empty_q;
  logic       run_last;
  logic       taken;
  logic [CpW-1:0] cp;

  assign cp = job_i.code_point;

  always_comb begin
    enc[0]     = cp[7:0];
    enc[1]     = 8'h00;
    enc[2]     = 8'h00;
    enc[3]     = 8'h00;
    last_idx_d = 2'd0;
    if (cp < OneByteEnd) begin
      enc[0]     = cp[7:0];
      last_idx_d = 2'd0;
    end else if (cp < TwoByteEnd) begin
      enc[0]     = {3'b110, cp[10:6]};
      enc[1]     = {2'b10, cp[5:0]};
      last_idx_d = 2'd1;
    end else if (cp < ThreeByteEnd) begin
      enc[0]     = {4'b1110, cp[15:12]};
      enc[1]     = {2'b10, cp[11:6]};
      enc[2]     = {2'b10, cp[5:0]};
      last_idx_d = 2'd2;
    end else begin
      enc[0]     = {5'b11110, cp[20:18]};
      enc[1]     = {2'b10, cp[17:12]};
      enc[2]     = {2'b10, cp[11:6]};
      enc[3]     = {2'b10, cp[5:0]};
      last_idx_d = 2'd3;
    end
  end

  assign run_last = idx_q == last_idx_q;
  assign taken    = busy_q && out_o.ready;
  assign pop_o    = valid_i && (!busy_q || (taken && run_last));

  assign out_o.valid      = busy_q;
  assign out_o.out_byte   = bytes_q[0];
  assign out_o.byte_valid = !empty_q;
  assign out_o.word_end   = word_end_q && run_last;
  assign out_o.run_last   = run_last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bytes_q[0] <= enc[0];
      bytes_q[1] <= enc[1];
      bytes_q[2] <= enc[2];
      bytes_q[3] <= enc[3];
      word_end_q <= job_i.word_end;
      empty_q    <= job_i.empty;
      last_idx_q <= last_idx_d;
    end else if (taken) begin
      bytes_q[0] <= bytes_q[1];
      bytes_q[1] <= bytes_q[2];
      bytes_q[2] <= bytes_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (taken) begin
      if (run_last) begin
        busy_q <= 1'b0;
      end
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

`default_nettype wire
